/* rtl/mrw_pkg.sv */
package mrw_pkg;

  // telegram byte positions and register codes
  localparam logic [7:0] OLD_STYLE_POS  = 8'd10;
  localparam logic [7:0] OLD_STYLE_MARK = 8'hB6;
  localparam logic [7:0] TOTAL_CODE     = 8'h10;
  localparam logic [7:0] POS_MAX        = 8'hFF;
  localparam logic [5:0] TOTAL_BYTES    = 6'd4;

  // report status codes
  localparam logic [1:0] STATUS_TOTAL = 2'd0;
  localparam logic [1:0] STATUS_NONE  = 2'd1;
  localparam logic [1:0] STATUS_OLD   = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } mrw_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] volume_litres;
  } mrw_out_t;

  // one byte handed from the input stage to the walker
  typedef struct packed {
    logic    valid;
    mrw_in_t item;
  } mrw_step_t;

  // one finished report handed from the walker to the output stage
  typedef struct packed {
    logic     valid;
    mrw_out_t report;
  } mrw_res_t;

  // payload size of a register code, zero when the code is unknown
  function automatic logic [5:0] payload_size(input logic [7:0] code);
    logic [5:0] sz;
    case (code) inside
      [8'hB6:8'hC7]:                                     sz = 6'd3;
      8'h00, 8'h10, 8'hA1, 8'h42, 8'hA0, 8'hA4, 8'hF0:   sz = 6'd4;
      8'h01, 8'h44, 8'hA6, 8'hD0, 8'hD3:                 sz = 6'd3;
      8'h11, 8'h41, 8'h43, 8'hA7, 8'hA8, 8'hAA, 8'hAB,
      8'hAC, 8'hAD, 8'hB4:                               sz = 6'd2;
      8'hA2, 8'hA5, 8'hA9, 8'hAF:                        sz = 6'd1;
      8'h40, 8'h8B, 8'h8C:                               sz = 6'd6;
      8'h71:                                             sz = 6'd9;
      8'h72:                                             sz = 6'd13;
      8'h73:                                             sz = 6'd17;
      8'h75:                                             sz = 6'd25;
      8'h7B:                                             sz = 6'd49;
      8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h86, 8'h87:   sz = 6'd10;
      8'h85, 8'h88, 8'h8F:                               sz = 6'd11;
      8'h8A:                                             sz = 6'd9;
      8'h8E, 8'hA3:                                      sz = 6'd7;
      8'hB0:                                             sz = 6'd5;
      8'hB1, 8'hB3:                                      sz = 6'd8;
      8'hB2, 8'hB5:                                      sz = 6'd16;
      default:                                           sz = 6'd0;
    endcase
    return sz;
  endfunction

endpackage

/* rtl/mrw_in_stage.sv */
module mrw_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              telegram_valid,
  output logic              telegram_stall,
  input  mrw_pkg::mrw_in_t  telegram,
  input  logic              slot_free,
  output mrw_pkg::mrw_step_t step
);

  logic             held_valid;
  mrw_pkg::mrw_in_t held;
  logic             advance;
  logic             accept;

  // a byte that makes no report never waits on the output side
  assign advance        = held_valid && (!held.last_byte || slot_free);
  assign telegram_stall = held_valid && !advance;
  assign accept         = telegram_valid && !telegram_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= telegram;
    end
  end

  assign step.valid = advance;
  assign step.item  = held;

endmodule

/* rtl/mrw_walk.sv */
module mrw_walk #(
  parameter int PAYLOAD_START = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  mrw_pkg::mrw_step_t step,
  output mrw_pkg::mrw_res_t  res
);

  localparam logic [7:0] START_POS = 8'(PAYLOAD_START);

  typedef enum logic [5:0] {
    PH_WAIT    = 6'b000001,
    PH_CODE    = 6'b000010,
    PH_SKIP    = 6'b000100,
    PH_CAPTURE = 6'b001000,
    PH_CONFIRM = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_t;

  logic [7:0]  byte_position, byte_position_next;
  phase_t      walk_phase, walk_phase_next;
  logic [5:0]  bytes_to_skip, bytes_to_skip_next;
  logic [31:0] capture_shift, capture_shift_next;
  logic        total_confirmed, total_confirmed_next;
  logic        old_style_seen, old_style_seen_next;

  phase_t      phase_eff;
  logic [7:0]  b;
  logic [5:0]  sz;
  logic [5:0]  skip_dec;

  assign b        = step.item.data_byte;
  assign sz       = mrw_pkg::payload_size(b);
  assign skip_dec = bytes_to_skip - 6'd1;

  always_comb begin
    byte_position_next   = byte_position;
    walk_phase_next      = walk_phase;
    bytes_to_skip_next   = bytes_to_skip;
    capture_shift_next   = capture_shift;
    total_confirmed_next = total_confirmed;
    old_style_seen_next  = old_style_seen;
    phase_eff            = walk_phase;
    res.valid            = 1'b0;
    res.report.status        = mrw_pkg::STATUS_NONE;
    res.report.volume_litres = 32'd0;

    if (step.valid) begin
      if (byte_position == mrw_pkg::OLD_STYLE_POS && b == mrw_pkg::OLD_STYLE_MARK) begin
        old_style_seen_next = 1'b1;
      end
      if (walk_phase == PH_WAIT && byte_position >= START_POS) begin
        phase_eff = PH_CODE;
      end
      walk_phase_next = phase_eff;

      case (phase_eff)
        PH_CODE: begin
          if (b == mrw_pkg::TOTAL_CODE) begin
            walk_phase_next    = PH_CAPTURE;
            bytes_to_skip_next = mrw_pkg::TOTAL_BYTES;
            capture_shift_next = 32'd0;
          end else if (sz == 6'd0) begin
            walk_phase_next = PH_DONE;
          end else begin
            bytes_to_skip_next = sz;
            walk_phase_next    = PH_SKIP;
          end
        end
        PH_SKIP: begin
          bytes_to_skip_next = skip_dec;
          if (skip_dec == 6'd0) walk_phase_next = PH_CODE;
        end
        PH_CAPTURE: begin
          // little-endian: each new byte enters at the top
          capture_shift_next = {b, capture_shift[31:8]};
          bytes_to_skip_next = skip_dec;
          if (skip_dec == 6'd0) walk_phase_next = PH_CONFIRM;
        end
        PH_CONFIRM: begin
          total_confirmed_next = 1'b1;
          walk_phase_next      = PH_DONE;
        end
        default: begin
        end
      endcase

      if (byte_position != mrw_pkg::POS_MAX) byte_position_next = byte_position + 8'd1;

      if (step.item.last_byte) begin
        res.valid = 1'b1;
        if (old_style_seen_next) begin
          res.report.status = mrw_pkg::STATUS_OLD;
        end else if (total_confirmed_next) begin
          res.report.status        = mrw_pkg::STATUS_TOTAL;
          res.report.volume_litres = capture_shift_next;
        end
        // back to the idle state for the next telegram
        byte_position_next   = 8'd0;
        walk_phase_next      = PH_WAIT;
        bytes_to_skip_next   = 6'd0;
        capture_shift_next   = 32'd0;
        total_confirmed_next = 1'b0;
        old_style_seen_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= 8'd0;
      walk_phase      <= PH_WAIT;
      bytes_to_skip   <= 6'd0;
      capture_shift   <= 32'd0;
      total_confirmed <= 1'b0;
      old_style_seen  <= 1'b0;
    end else begin
      byte_position   <= byte_position_next;
      walk_phase      <= walk_phase_next;
      bytes_to_skip   <= bytes_to_skip_next;
      capture_shift   <= capture_shift_next;
      total_confirmed <= total_confirmed_next;
      old_style_seen  <= old_style_seen_next;
    end
  end

`ifndef ASSERT_OFF
  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    walk_phase == PH_SKIP |-> bytes_to_skip != 6'd0)
    else $error("skip phase with empty skip count");

  a_capture_count: assert property (@(posedge clk) disable iff (rst)
    walk_phase == PH_CAPTURE |-> bytes_to_skip != 6'd0 && bytes_to_skip <= mrw_pkg::TOTAL_BYTES)
    else $error("capture count out of range");

  a_confirm_done: assert property (@(posedge clk) disable iff (rst)
    total_confirmed |-> walk_phase == PH_DONE)
    else $error("confirmed total while still walking");

  a_report_resets: assert property (@(posedge clk) disable iff (rst)
    step.valid && step.item.last_byte |=> byte_position == 8'd0 && walk_phase == PH_WAIT)
    else $error("walker not cleared after report");
`endif

endmodule

/* rtl/mrw_out_stage.sv */
module mrw_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  mrw_pkg::mrw_res_t res,
  output logic              slot_free,
  output logic              report_valid,
  input  logic              report_stall,
  output mrw_pkg::mrw_out_t report
);

  assign slot_free = !report_valid || !report_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (slot_free) begin
      report_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && res.valid) begin
      report <= res.report;
    end
  end

endmodule

/* rtl/meter_register_walk_total_extract.sv */
// Meter telegram total extractor. Bytes of a decrypted telegram come in one
// request per byte, the final byte flagged by last_byte. From byte
// PAYLOAD_START on, the walker reads register codes, skips their payloads
// by a fixed size table, and captures the four little-endian payload bytes
// of code 0x10 as the total volume in litres; that total counts only if at
// least one more byte follows it. Code 0xFF, an unknown code or a telegram
// cut inside a payload ends the walk. A telegram whose byte 10 is 0xB6 is
// old style and reported as such. Exactly one report comes out per
// telegram, on its last byte, and nothing for the other bytes. A byte can
// be taken every cycle while the input side does not stall: each passes an
// input register, a walker step (table lookup and counter update), and a
// report register. The input side stalls only while a report waits behind
// a stalled output.
module meter_register_walk_total_extract #(
  parameter int PAYLOAD_START = 25
) (
  input  logic              clk,
  input  logic              rst,
  // telegram byte requests
  input  logic              telegram_valid,
  output logic              telegram_stall,
  input  mrw_pkg::mrw_in_t  telegram,
  // status and volume reports
  output logic              report_valid,
  input  logic              report_stall,
  output mrw_pkg::mrw_out_t report
);

  mrw_pkg::mrw_step_t step;   // byte leaving the input register
  mrw_pkg::mrw_res_t  res;    // report leaving the walker
  logic               slot_free;

  // input register, releases a telegram's last byte once its report has room
  mrw_in_stage u_in (
    .clk            (clk),
    .rst            (rst),
    .telegram_valid (telegram_valid),
    .telegram_stall (telegram_stall),
    .telegram       (telegram),
    .slot_free      (slot_free),
    .step           (step)
  );

  // register walker, one byte per cycle while the input register releases bytes
  mrw_walk #(
    .PAYLOAD_START (PAYLOAD_START)
  ) u_walk (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .res  (res)
  );

  // report register
  mrw_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .slot_free    (slot_free),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .report       (report)
  );

endmodule
